// ----- hdl/sfmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmr_pkg
// shared types and constants of the first-match replace stream block
// ----------------------------------------------------------------------------
package sfmr_pkg;

    // longest pattern the matcher compares
    localparam int unsigned PATTERN_MAX = 8;
    // longest replacement
    localparam int unsigned REPL_MAX    = 8;
    // apb address width: four 64-bit registers at 8*i
    localparam int unsigned CFG_AW      = 5;
    localparam int unsigned CFG_DW      = 64;

    typedef logic [7:0][7:0] t_bytes;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_reg_idx;

    // configuration seen by the datapath
    typedef struct packed {
        t_bytes     pattern;
        logic [3:0] pattern_len;
        t_bytes     repl;
        logic [3:0] repl_len;
        logic       clear_held;
    } t_cfg;

    // matcher result
    typedef struct packed {
        logic [3:0] held;
        logic [3:0] shift;
        logic       hit;
    } t_match;

    // result list of one input word, handed to the output stage
    typedef struct packed {
        logic       vld;
        t_bytes     base;
        logic [3:0] base_cnt;
        logic [7:0] ch;
        logic [3:0] cnt;
        logic       line_end;
    } t_load;

endpackage

// ----- hdl/sfmr_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmr_in_if
// input word channel: one byte of a line with its end marker
// ----------------------------------------------------------------------------
interface sfmr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

// ----- hdl/sfmr_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmr_out_if
// output word channel: one byte of the edited line with its end marker
// ----------------------------------------------------------------------------
interface sfmr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       line_done;

    modport source (output valid, output char_out, output line_done, input ready);
    modport sink   (input valid, input char_out, input line_done, output ready);
endinterface

// ----- hdl/sfmr_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmr_cfg
// apb register file holding pattern and replacement
// ----------------------------------------------------------------------------
module sfmr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfmr_pkg::CFG_AW-1:0]   paddr,
    input  logic [sfmr_pkg::CFG_DW-1:0]   pwdata,
    output logic [sfmr_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output sfmr_pkg::t_cfg                o_cfg
);

    logic [63:0]         r_pattern;
    logic [3:0]          r_pattern_len;
    logic [63:0]         r_repl;
    logic [3:0]          r_repl_len;
    logic                wr_en;
    sfmr_pkg::t_reg_idx  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = sfmr_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= '0;
            r_pattern_len <= '0;
            r_repl        <= '0;
            r_repl_len    <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                sfmr_pkg::REG_PATTERN_BYTES:      r_pattern     <= pwdata;
                sfmr_pkg::REG_PATTERN_LENGTH:     r_pattern_len <= pwdata[3:0];
                sfmr_pkg::REG_REPLACEMENT_BYTES:  r_repl        <= pwdata;
                sfmr_pkg::REG_REPLACEMENT_LENGTH: r_repl_len    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sfmr_pkg::REG_PATTERN_BYTES:      prdata = r_pattern;
            sfmr_pkg::REG_PATTERN_LENGTH:     prdata = {60'd0, r_pattern_len};
            sfmr_pkg::REG_REPLACEMENT_BYTES:  prdata = r_repl;
            sfmr_pkg::REG_REPLACEMENT_LENGTH: prdata = {60'd0, r_repl_len};
            default:                          prdata = '0;
        endcase
    end

    // a pattern write drops any held partial match
    assign o_cfg.pattern     = r_pattern;
    assign o_cfg.pattern_len = r_pattern_len;
    assign o_cfg.repl        = r_repl;
    assign o_cfg.repl_len    = r_repl_len;
    assign o_cfg.clear_held  = wr_en && ((reg_idx == sfmr_pkg::REG_PATTERN_BYTES) ||
                                         (reg_idx == sfmr_pkg::REG_PATTERN_LENGTH));

endmodule

// ----- hdl/sfmr_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmr_match
// leftmost-first rescan of held prefix plus new byte against the pattern
// ----------------------------------------------------------------------------
module sfmr_match (
    input  logic [7:0]        i_char,
    input  logic [3:0]        i_held,
    input  logic [3:0]        i_plen,
    input  sfmr_pkg::t_bytes  i_pattern,
    output sfmr_pkg::t_match  o_match
);

    logic [7:0] win [8];
    logic [7:0] ok;
    logic [2:0] held;
    logic [3:0] len;
    logic [3:0] shift;
    logic       found;

    // held bytes are pattern bytes, the new byte sits right after them
    assign held = (i_held >= i_plen) ? 3'd0 : i_held[2:0];
    assign len  = {1'b0, held} + 4'd1;

    always_comb begin
        for (int p = 0; p < 8; p++) begin
            win[p] = (3'(p) < held) ? i_pattern[p] : i_char;
        end
    end

    // ok[s]: window starting at s agrees with the pattern as far as both go
    always_comb begin
        for (int s = 0; s < 8; s++) begin
            ok[s] = 1'b1;
            for (int i = 0; i < 8; i++) begin
                if ((s + i < 8) && (4'(s + i) < len) && (4'(i) < i_plen) &&
                    (win[(s + i) % 8] != i_pattern[i])) begin
                    ok[s] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        found = 1'b0;
        shift = len;
        for (int s = 0; s < 8; s++) begin
            if (!found && (4'(s) < len) && ok[s]) begin
                shift = 4'(s);
                found = 1'b1;
            end
        end
    end

    assign o_match.held  = {1'b0, held};
    assign o_match.shift = shift;
    assign o_match.hit   = (shift == 4'd0) && (len == i_plen);

endmodule

// ----- hdl/sfmr_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmr_out
// result register that plays out the result list of one word byte by byte
// ----------------------------------------------------------------------------
module sfmr_out (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfmr_pkg::t_load       i_load,
    output logic                  o_free,
    sfmr_out_if.source            o_line
);

    logic              r_vld;
    sfmr_pkg::t_bytes  r_base;
    logic [3:0]        r_base_cnt;
    logic [7:0]        r_ch;
    logic [3:0]        r_cnt;
    logic              r_line_end;
    logic [3:0]        r_idx;
    logic              last;
    logic              take;

    assign last   = (r_idx == (r_cnt - 4'd1));
    assign take   = r_vld && o_line.ready;
    assign o_free = !r_vld || (take && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (o_free) begin
            r_vld <= i_load.vld;
            r_idx <= '0;
        end else if (take) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load.vld) begin
            r_base     <= i_load.base;
            r_base_cnt <= i_load.base_cnt;
            r_ch       <= i_load.ch;
            r_cnt      <= i_load.cnt;
            r_line_end <= i_load.line_end;
        end
    end

    assign o_line.valid     = r_vld;
    assign o_line.char_out  = (r_idx < r_base_cnt) ? r_base[r_idx[2:0]] : r_ch;
    assign o_line.line_done = r_line_end && last;

endmodule

// ----- hdl/stream_first_match_replace.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_first_match_replace
// replaces the first occurrence of a pattern in each streamed line
// ----------------------------------------------------------------------------
// Takes one byte of a line per word and replaces the first occurrence of the
// configured pattern (up to 8 bytes) with the replacement (up to 8 bytes),
// once per line. Bytes that could still start the pattern are held back and
// released leftmost-first on a mismatch; an empty pattern inserts the
// replacement before the first byte. Only the first LINE_BUFFER-1 bytes of a
// line are kept. A line that ends with nothing to show gives one word with
// char_out 0 and line_done set. Rate: an input word is taken every cycle as
// long as each word yields at most one output word and the output side is
// ready; a word that yields n output words (up to 9, from a replacement or a
// release of held bytes) holds the output register until all n are taken,
// and the input side stalls behind it after one word of buffering. A word
// passes the input register, then the result register. Write the
// configuration registers only while no line bytes are in flight.
// ----------------------------------------------------------------------------
module stream_first_match_replace #(
    parameter int unsigned LINE_BUFFER = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sfmr_in_if.sink                       i_line,
    sfmr_out_if.source                    o_line,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfmr_pkg::CFG_AW-1:0]   paddr,
    input  logic [sfmr_pkg::CFG_DW-1:0]   pwdata,
    output logic [sfmr_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned SEEN_W = (LINE_BUFFER > 2) ? $clog2(LINE_BUFFER) : 1;

    sfmr_pkg::t_cfg    cfg;
    sfmr_pkg::t_match  match;
    sfmr_pkg::t_load   load;
    logic              out_free;

    // input register
    logic              r_a_vld;
    logic [7:0]        r_a_char;
    logic              r_a_end;
    logic              a_take;

    // line state
    logic [3:0]        r_held;
    logic              r_replaced;
    logic [SEEN_W-1:0] r_seen;
    logic [3:0]        n_held;
    logic              n_replaced;
    logic [SEEN_W-1:0] n_seen;

    // effective lengths and result list of the word in the input register
    logic [3:0]        plen;
    logic [3:0]        rlen;
    logic              keep;
    logic [3:0]        len;
    sfmr_pkg::t_bytes  base;
    logic [3:0]        base_cnt;
    logic [7:0]        ch;
    logic [3:0]        cnt;

    sfmr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // oversized lengths saturate
    assign plen = (cfg.pattern_len > 4'(sfmr_pkg::PATTERN_MAX)) ?
                  4'(sfmr_pkg::PATTERN_MAX) : cfg.pattern_len;
    assign rlen = (cfg.repl_len > 4'(sfmr_pkg::REPL_MAX)) ?
                  4'(sfmr_pkg::REPL_MAX) : cfg.repl_len;

    sfmr_match u_match (
        .i_char    (r_a_char),
        .i_held    (r_held),
        .i_plen    (plen),
        .i_pattern (cfg.pattern),
        .o_match   (match)
    );

    assign keep = (r_seen < SEEN_W'(LINE_BUFFER - 1));
    assign len  = match.held + 4'd1;

    // result list: base[0 .. base_cnt-1], then ch, cut to cnt words
    always_comb begin
        base       = cfg.pattern;
        base_cnt   = (r_held > 4'd8) ? 4'd8 : r_held;
        ch         = r_a_char;
        cnt        = base_cnt;
        n_held     = '0;
        n_replaced = r_replaced;
        n_seen     = r_seen;
        if (keep) begin
            n_seen = r_seen + SEEN_W'(1);
            if (r_replaced) begin
                // already replaced: pass through
                base_cnt = '0;
                cnt      = 4'd1;
                n_held   = r_held;
            end else if (plen == 4'd0) begin
                // empty pattern: insert replacement before this byte
                base       = cfg.repl;
                base_cnt   = rlen;
                cnt        = rlen + 4'd1;
                n_replaced = 1'b1;
            end else if (match.hit) begin
                base       = cfg.repl;
                base_cnt   = rlen;
                cnt        = rlen;
                n_replaced = 1'b1;
            end else begin
                // release bytes before the surviving prefix, at line end all
                base     = cfg.pattern;
                base_cnt = match.held;
                cnt      = r_a_end ? len : match.shift;
                n_held   = r_a_end ? 4'd0 : (len - match.shift);
            end
        end
        if (r_a_end) begin
            n_held     = '0;
            n_replaced = 1'b0;
            n_seen     = '0;
            if (cnt == 4'd0) begin
                // end marker with no byte
                base_cnt = '0;
                ch       = 8'd0;
                cnt      = 4'd1;
            end
        end
    end

    // a word with no results leaves without waiting for the output stage
    assign a_take        = r_a_vld && ((cnt == 4'd0) || out_free);
    assign i_line.ready  = !r_a_vld || a_take;

    assign load.vld      = r_a_vld && (cnt != 4'd0);
    assign load.base     = base;
    assign load.base_cnt = base_cnt;
    assign load.ch       = ch;
    assign load.cnt      = cnt;
    assign load.line_end = r_a_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_line.ready) begin
            r_a_vld <= i_line.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line.valid && i_line.ready) begin
            r_a_char <= i_line.char_in;
            r_a_end  <= i_line.line_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_replaced <= 1'b0;
            r_seen     <= '0;
        end else begin
            if (a_take) begin
                r_held     <= n_held;
                r_replaced <= n_replaced;
                r_seen     <= n_seen;
            end
            // the user must write the pattern only while idle; the block does not enforce it
            if (cfg.clear_held) begin
                r_held <= '0;
            end
        end
    end

    sfmr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .o_free  (out_free),
        .o_line  (o_line)
    );

endmodule
